### hw/rtl/cbi_pkg.sv
// Package for the checkerboard site index to coordinates block.
// Holds the widths, the divider geometry and the types shared by cbi_cfg, cbi_div
// and the top level. No dependencies.
package cbi_pkg;

  localparam int DIMS             = 4;
  localparam int MAX_LOCAL_EXTENT = 32;
  localparam int MAX_GRID_EXTENT  = 16;

  localparam int LE_W    = 6;   // local extent register width
  localparam int GE_W    = 5;   // grid extent register width
  localparam int RANK_W  = 16;
  localparam int IDX_W   = 20;
  localparam int COORD_W = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 6;

  localparam int MC_W    = 4;   // node coordinate, below MAX_GRID_EXTENT
  localparam int LC_W    = 5;   // local coordinate, below MAX_LOCAL_EXTENT
  localparam int SITES_W = 21;  // up to MAX_LOCAL_EXTENT**4
  localparam int P2_W    = 11;  // product of two local extents

  // Divider: restoring, DIV_STEPS quotient bits per register stage.
  localparam int DIV_STG   = 3;
  localparam int DIV_STEPS = 7;
  localparam int DIV_QW    = DIV_STG * DIV_STEPS;
  localparam int DIV_DW    = 6;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_T = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Z  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_T  = 3'd7;

  typedef struct packed {
    logic [IDX_W-1:0]           idx;
    logic [DIMS-1:0][MC_W-1:0]  mc;   // node grid coordinates
    logic [DIMS-1:0][LC_W-1:0]  lc;   // local coordinates
    logic                       xeo;  // odd half selected
    logic                       bad;
  } item_t;

  typedef struct packed {
    logic [DIMS-1:0][LE_W-1:0]  le;   // clamped local extents
    logic [DIMS-1:0][GE_W-1:0]  ge;   // clamped grid extents
    logic [SITES_W-1:0]         sites;
  } cfg_t;

endpackage

### hw/rtl/checkerboard_index_to_coords.sv
// Top level: node rank and checkerboard site index to global 4D coordinates.
// Depends on cbi_pkg, cbi_cfg and cbi_div.
//
// Takes one beat per clock unless the result side stalls, and returns one result
// beat per input beat, in order. The pipe is eight chained dividers of three
// stages each (four to split the rank over the node grid, four to split the
// site position over the local block), one stage for the even/odd half select,
// one for the node origin products and the output register. A result-side stall
// freezes the whole pipe; nothing is dropped. The sites product is registered in cbi_cfg.
module checkerboard_index_to_coords (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [cbi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cbi_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cbi_pkg::RANK_W-1:0]        in_node_rank,
  input  logic [cbi_pkg::IDX_W-1:0]         in_site_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cbi_pkg::COORD_W-1:0]       out_coord_x,
  output logic [cbi_pkg::COORD_W-1:0]       out_coord_y,
  output logic [cbi_pkg::COORD_W-1:0]       out_coord_z,
  output logic [cbi_pkg::COORD_W-1:0]       out_coord_t,
  output logic                              out_index_bad
);
  import cbi_pkg::*;

  localparam int NDIV = 2 * DIMS;

  cfg_t cfg;
  logic en;

  logic              dv_in_v   [NDIV];
  logic [DIV_QW-1:0] dv_in_num [NDIV];
  logic [DIV_DW-1:0] dv_in_den [NDIV];
  item_t             dv_in_it  [NDIV];
  logic              dv_out_v  [NDIV];
  logic [DIV_QW-1:0] dv_out_quo[NDIV];
  logic [DIV_DW-1:0] dv_out_rem[NDIV];
  item_t             dv_out_it [NDIV];

  // half select stage
  logic              tl_v_r;
  logic [DIV_QW-1:0] tl_ir_r;
  item_t             tl_it_r;
  logic [DIV_QW-1:0] tl_ir_nxt;
  item_t             tl_it_nxt;

  // origin stage
  logic                         og_v_r;
  logic [DIMS-1:0][COORD_W-1:0] og_org_r;
  logic [DIMS-1:0][LC_W-1:0]    og_lc_r;
  logic                         og_xeo_r, og_bad_r;
  logic [DIMS-1:0][COORD_W-1:0] og_org_nxt;
  item_t                        last_it;

  logic                         out_valid_r;
  logic [DIMS-1:0][COORD_W-1:0] coord_r, coord_nxt;
  logic                         bad_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  cbi_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  always_comb begin
    item_t it0;
    it0     = '0;
    it0.idx = in_site_index;
    for (int j = 0; j < NDIV; j++) begin
      if (j == 0) begin
        dv_in_v[j]   = in_valid && en;
        dv_in_num[j] = DIV_QW'(in_node_rank);
        dv_in_it[j]  = it0;
      end else if (j == DIMS) begin
        dv_in_v[j]   = tl_v_r;
        dv_in_num[j] = tl_ir_r;
        dv_in_it[j]  = tl_it_r;
      end else begin
        dv_in_v[j]   = dv_out_v[j-1];
        dv_in_num[j] = dv_out_quo[j-1];
        dv_in_it[j]  = dv_out_it[j-1];
        if (j < DIMS)
          dv_in_it[j].mc[j-1] = dv_out_rem[j-1][MC_W-1:0];
        else
          dv_in_it[j].lc[j-1-DIMS] = dv_out_rem[j-1][LC_W-1:0];
      end
      if (j < DIMS)
        dv_in_den[j] = DIV_DW'(cfg.ge[j]);
      else
        dv_in_den[j] = DIV_DW'(cfg.le[j-DIMS]);
    end
  end

  for (genvar j = 0; j < NDIV; j++) begin : g_div
    cbi_div u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_v     (dv_in_v[j]),
      .in_num   (dv_in_num[j]),
      .in_den   (dv_in_den[j]),
      .in_item  (dv_in_it[j]),
      .out_v    (dv_out_v[j]),
      .out_quo  (dv_out_quo[j]),
      .out_rem  (dv_out_rem[j]),
      .out_item (dv_out_it[j])
    );
  end

  // node parity picks how many even sites this node holds
  always_comb begin
    logic                 meo;
    logic [SITES_W:0]     neven_full;
    logic [SITES_W-1:0]   neven, idx_w, diff;
    tl_it_nxt = dv_out_it[DIMS-1];
    tl_it_nxt.mc[DIMS-1] = dv_out_rem[DIMS-1][MC_W-1:0];
    meo = 1'b0;
    for (int d = 0; d < DIMS; d++)
      meo = meo ^ tl_it_nxt.mc[d][0];
    neven_full = {1'b0, cfg.sites} + (SITES_W+1)'(1) - (SITES_W+1)'(meo);
    neven      = neven_full[SITES_W:1];
    idx_w      = SITES_W'(tl_it_nxt.idx);
    diff       = idx_w - neven;
    tl_it_nxt.bad = (idx_w >= cfg.sites);
    tl_it_nxt.xeo = !(idx_w < neven);
    if (tl_it_nxt.xeo)
      tl_ir_nxt = {diff[DIV_QW-2:0], 1'b0};
    else
      tl_ir_nxt = {idx_w[DIV_QW-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tl_v_r <= 1'b0;
    end else if (en) begin
      tl_v_r <= dv_out_v[DIMS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tl_ir_r <= tl_ir_nxt;
      tl_it_r <= tl_it_nxt;
    end
  end

  always_comb begin
    logic [MC_W+LE_W-1:0] prod;
    last_it = dv_out_it[NDIV-1];
    last_it.lc[DIMS-1] = dv_out_rem[NDIV-1][LC_W-1:0];
    for (int d = 0; d < DIMS; d++) begin
      prod          = last_it.mc[d] * cfg.le[d];
      og_org_nxt[d] = prod[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      og_v_r <= 1'b0;
    end else if (en) begin
      og_v_r <= dv_out_v[NDIV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      og_org_r <= og_org_nxt;
      og_lc_r  <= last_it.lc;
      og_xeo_r <= last_it.xeo;
      og_bad_r <= last_it.bad;
    end
  end

  // parity fix: bump local x, carry into y, z, t inside the block; t keeps its overflow
  always_comb begin
    logic [COORD_W-1:0] c;
    logic               par, carry;
    logic [LE_W-1:0]    n;
    par = 1'b0;
    for (int d = 0; d < DIMS; d++) begin
      c   = og_org_r[d] + COORD_W'(og_lc_r[d]);
      par = par ^ c[0];
    end
    carry = (par != og_xeo_r);
    for (int d = 0; d < DIMS; d++) begin
      n = LE_W'(og_lc_r[d]) + LE_W'(carry);
      if (d < DIMS-1 && carry && n == cfg.le[d]) begin
        n     = '0;
        carry = 1'b1;
      end else begin
        carry = 1'b0;
      end
      coord_nxt[d] = og_bad_r ? '0 : og_org_r[d] + COORD_W'(n);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= og_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coord_r <= coord_nxt;
      bad_r   <= og_bad_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_coord_x   = coord_r[0];
  assign out_coord_y   = coord_r[1];
  assign out_coord_z   = coord_r[2];
  assign out_coord_t   = coord_r[3];
  assign out_index_bad = bad_r;

`ifndef NO_ASSERTIONS
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_index_bad |->
      (out_coord_x == '0 && out_coord_y == '0 && out_coord_z == '0 && out_coord_t == '0))
    else $error("bad index beat carries nonzero coordinates");

  a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    tl_v_r && !en |=> tl_v_r && $stable(tl_ir_r))
    else $error("half select stage lost its item during a stall");

  a_origin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    og_v_r && !en |=> og_v_r && $stable(og_org_r))
    else $error("origin stage changed during a stall");
`endif

endmodule

### hw/rtl/cbi_cfg.sv
// Configuration registers with extent clamping and the sites-per-node product.
// Depends on cbi_pkg.
module cbi_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [cbi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbi_pkg::CFG_DAT_W-1:0]  cfg_data,
  output cbi_pkg::cfg_t                  cfg
);
  import cbi_pkg::*;

  logic [DIMS-1:0][LE_W-1:0] le_r;
  logic [DIMS-1:0][GE_W-1:0] ge_r;
  logic [P2_W-1:0]           p01_r, p23_r;
  logic [SITES_W-1:0]        sites_r;
  logic [2*LE_W-1:0]         p01_full, p23_full;
  logic [2*P2_W-1:0]         sites_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < DIMS; d++) begin
        le_r[d] <= LE_W'(4);
        ge_r[d] <= GE_W'(1);
      end
    end else if (cfg_wr_en) begin
      if (cfg_index <= REG_LOCAL_T) begin
        le_r[cfg_index[1:0]] <= cfg_data[LE_W-1:0];
      end else if (cfg_index >= REG_GRID_X) begin
        ge_r[cfg_index[1:0]] <= cfg_data[GE_W-1:0];
      end
    end
  end

  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      if (le_r[d] == '0)
        cfg.le[d] = LE_W'(1);
      else if (le_r[d] > LE_W'(MAX_LOCAL_EXTENT))
        cfg.le[d] = LE_W'(MAX_LOCAL_EXTENT);
      else
        cfg.le[d] = le_r[d];
      if (ge_r[d] == '0)
        cfg.ge[d] = GE_W'(1);
      else if (ge_r[d] > GE_W'(MAX_GRID_EXTENT))
        cfg.ge[d] = GE_W'(MAX_GRID_EXTENT);
      else
        cfg.ge[d] = ge_r[d];
    end
    cfg.sites = sites_r;
  end

  assign p01_full   = cfg.le[0] * cfg.le[1];
  assign p23_full   = cfg.le[2] * cfg.le[3];
  assign sites_full = p01_r * p23_r;

  // p01/p23 feed sites_r after a write; first use is well down the pipe
  always_ff @(posedge clk) begin
    p01_r   <= p01_full[P2_W-1:0];
    p23_r   <= p23_full[P2_W-1:0];
    sites_r <= sites_full[SITES_W-1:0];
  end

endmodule

### hw/rtl/cbi_div.sv
// Pipelined restoring divider, DIV_STEPS quotient bits per stage, item carried alongside.
// Depends on cbi_pkg.
module cbi_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_v,
  input  logic [cbi_pkg::DIV_QW-1:0]   in_num,
  input  logic [cbi_pkg::DIV_DW-1:0]   in_den,
  input  cbi_pkg::item_t               in_item,
  output logic                         out_v,
  output logic [cbi_pkg::DIV_QW-1:0]   out_quo,
  output logic [cbi_pkg::DIV_DW-1:0]   out_rem,
  output cbi_pkg::item_t               out_item
);
  import cbi_pkg::*;

  logic              v_r  [DIV_STG];
  logic [DIV_QW-1:0] q_r  [DIV_STG];
  logic [DIV_DW-1:0] a_r  [DIV_STG];
  logic [DIV_DW-1:0] d_r  [DIV_STG];
  item_t             it_r [DIV_STG];

  logic              v_nxt  [DIV_STG];
  logic [DIV_QW-1:0] q_nxt  [DIV_STG];
  logic [DIV_DW-1:0] a_nxt  [DIV_STG];
  logic [DIV_DW-1:0] d_nxt  [DIV_STG];
  item_t             it_nxt [DIV_STG];

  for (genvar s = 0; s < DIV_STG; s++) begin : g_stg
    logic              src_v;
    logic [DIV_QW-1:0] src_q;
    logic [DIV_DW-1:0] src_a, src_d;
    item_t             src_it;

    if (s == 0) begin : g_first
      assign src_v  = in_v;
      assign src_q  = in_num;
      assign src_a  = '0;
      assign src_d  = in_den;
      assign src_it = in_item;
    end else begin : g_next
      assign src_v  = v_r[s-1];
      assign src_q  = q_r[s-1];
      assign src_a  = a_r[s-1];
      assign src_d  = d_r[s-1];
      assign src_it = it_r[s-1];
    end

    always_comb begin
      logic [DIV_QW-1:0] q;
      logic [DIV_DW-1:0] a;
      logic [DIV_DW:0]   t;
      v_nxt[s]  = src_v;
      d_nxt[s]  = src_d;
      it_nxt[s] = src_it;
      q = src_q;
      a = src_a;
      for (int k = 0; k < DIV_STEPS; k++) begin
        t = {a, q[DIV_QW-1]};
        q = {q[DIV_QW-2:0], 1'b0};
        if (t >= {1'b0, src_d}) begin
          t    = t - {1'b0, src_d};
          q[0] = 1'b1;
        end
        a = t[DIV_DW-1:0];
      end
      q_nxt[s] = q;
      a_nxt[s] = a;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_nxt[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s]  <= q_nxt[s];
        a_r[s]  <= a_nxt[s];
        d_r[s]  <= d_nxt[s];
        it_r[s] <= it_nxt[s];
      end
    end
  end

  assign out_v    = v_r[DIV_STG-1];
  assign out_quo  = q_r[DIV_STG-1];
  assign out_rem  = a_r[DIV_STG-1];
  assign out_item = it_r[DIV_STG-1];

endmodule
